// ----- rtl/cpts_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_pkg: shared types and codes
// Operation, status and notify codes, payload structs and the
// controller-to-datapath command and status structs.
// ----------------------------------------------------------------------------
package cpts_pkg;

    localparam logic [2:0] OP_SUBMIT   = 3'd0;
    localparam logic [2:0] OP_TAKE     = 3'd1;
    localparam logic [2:0] OP_COMPLETE = 3'd2;
    localparam logic [2:0] OP_FAIL     = 3'd3;
    localparam logic [2:0] OP_CANCEL   = 3'd4;
    localparam logic [2:0] OP_CLOSE    = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_JOINED   = 3'd1;
    localparam logic [2:0] ST_REQUEUED = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_CLOSED   = 3'd4;
    localparam logic [2:0] ST_WRONG    = 3'd5;
    localparam logic [2:0] ST_NOTFOUND = 3'd6;
    localparam logic [2:0] ST_FULL     = 3'd7;

    localparam logic [1:0] NF_NONE      = 2'd0;
    localparam logic [1:0] NF_COMPLETED = 2'd1;
    localparam logic [1:0] NF_FAILED    = 2'd2;

    localparam logic CFG_PRIO_DIR    = 1'b0;
    localparam logic CFG_RETRY_LIMIT = 1'b1;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] task_id;
        logic [7:0]  priority_req;
        logic        retryable;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_id;
        logic [7:0]  out_priority;
        logic [1:0]  out_retries;
        logic [1:0]  notify;
    } t_out_item;

    // Controller to datapath.
    typedef struct packed {
        logic clear_scan;   // restart the scan at slot zero
        logic step_scan;    // examine the current slot
        logic commit;       // apply the operation and emit the result
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;    // the current slot is the last one
    } t_dp_sts;

endpackage

// ----- rtl/coalescing_priority_transfer_scheduler.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_priority_transfer_scheduler: priority transfer slot table
// Coalesces submits by id, serves queued transfers by priority and arrival
// order, and handles complete, fail with retry, cancel and close.
// ----------------------------------------------------------------------------
// Channel  | Ports                          | Transfer
// command  | start, busy, i_cmd             | accepted when start && !busy
// result   | o_done, o_res                  | one-cycle strobe, cannot stall
// config   | i_cfg_we, i_cfg_idx, i_cfg_data| written when i_cfg_we is high
//
// Each transaction runs a slot scan that examines one slot per cycle, then the
// commit state registers the result.
// busy stays high until the cycle before the strobe; a new transaction may
// be accepted in the cycle the result is shown.
// Reset clears all valid bits at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module coalescing_priority_transfer_scheduler #(
    parameter int SLOTS      = 16,
    parameter int ORDER_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cpts_pkg::t_in_item   i_cmd,
    output logic                 o_done,
    output cpts_pkg::t_out_item  o_res,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [1:0]           i_cfg_data
);

    cpts_pkg::t_dp_cmd dp_cmd;
    cpts_pkg::t_dp_sts dp_sts;
    logic load;
    logic r_larger_first;
    logic [1:0] r_retry_limit;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_larger_first <= 1'b1;
            r_retry_limit  <= 2'd2;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == cpts_pkg::CFG_PRIO_DIR) begin
                r_larger_first <= i_cfg_data[0];
            end else begin
                r_retry_limit <= i_cfg_data;
            end
        end
    end

    cpts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (dp_sts),
        .o_busy  (busy),
        .o_load  (load),
        .o_cmd   (dp_cmd)
    );

    cpts_dp #(.SLOTS(SLOTS), .ORDER_BITS(ORDER_BITS)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (load),
        .i_item         (i_cmd),
        .i_cmd          (dp_cmd),
        .i_larger_first (r_larger_first),
        .i_retry_limit  (r_retry_limit),
        .o_sts          (dp_sts),
        .o_done         (o_done),
        .o_res          (o_res)
    );

endmodule

// ----- rtl/cpts_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_ctrl: sequencer
// Accepts a transaction, walks the datapath over every slot, then commits.
// ----------------------------------------------------------------------------
module cpts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  cpts_pkg::t_dp_sts  i_sts,
    output logic               o_busy,
    output logic               o_load,
    output cpts_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_load           = 1'b1;
                    o_cmd.clear_scan = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step_scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- rtl/cpts_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_dp: slot table and scan datapath
// Holds the slots, scans them one per cycle for id match, first free slot
// and best queued slot, and applies the operation at commit.
// ----------------------------------------------------------------------------
module cpts_dp #(
    parameter int SLOTS      = 16,
    parameter int ORDER_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  cpts_pkg::t_in_item   i_item,
    input  cpts_pkg::t_dp_cmd    i_cmd,
    input  logic                 i_larger_first,
    input  logic [1:0]           i_retry_limit,
    output cpts_pkg::t_dp_sts    o_sts,
    output logic                 o_done,
    output cpts_pkg::t_out_item  o_res
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    logic                  r_valid [SLOTS];
    logic [15:0]           r_id    [SLOTS];
    logic [7:0]            r_prio  [SLOTS];
    logic [ORDER_BITS-1:0] r_order [SLOTS];
    logic                  r_run   [SLOTS];
    logic [1:0]            r_retr  [SLOTS];
    logic [ORDER_BITS-1:0] r_next_order;
    logic                  r_shut;

    cpts_pkg::t_in_item r_item;
    logic [IW-1:0]      r_idx;
    logic               r_hit, r_free_ok, r_best_ok;
    logic [IW-1:0]      r_hit_idx, r_free_idx, r_best_idx;
    logic [7:0]         r_best_prio;
    logic [ORDER_BITS-1:0] r_best_order;
    cpts_pkg::t_out_item r_res;
    logic                r_done;

    // Comparison of the current slot against the best so far.
    logic better;
    always_comb begin
        if (r_prio[r_idx] != r_best_prio) begin
            better = i_larger_first ? (r_prio[r_idx] > r_best_prio)
                                    : (r_prio[r_idx] < r_best_prio);
        end else begin
            better = r_order[r_idx] < r_best_order;
        end
    end

    assign o_sts.scan_last = (r_idx == LAST);

    // Scan registers.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_item;
        end
        if (i_cmd.clear_scan) begin
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
            r_best_ok <= 1'b0;
        end else if (i_cmd.step_scan) begin
            if (r_idx != LAST) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_valid[r_idx] && r_id[r_idx] == r_item.task_id && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_idx;
            end
            if (!r_valid[r_idx] && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_idx;
            end
            if (r_valid[r_idx] && !r_run[r_idx] && (!r_best_ok || better)) begin
                r_best_ok    <= 1'b1;
                r_best_idx   <= r_idx;
                r_best_prio  <= r_prio[r_idx];
                r_best_order <= r_order[r_idx];
            end
        end
    end

    // Commit: decide the result and the table update.
    cpts_pkg::t_out_item n_res;
    logic          wr_en, wr_valid, wr_run, wr_new, set_shut;
    logic [IW-1:0] wr_idx;
    logic [1:0]    wr_retr;
    always_comb begin
        n_res    = '0;
        wr_en    = 1'b0;
        wr_valid = 1'b0;
        wr_run   = 1'b0;
        wr_new   = 1'b0;
        wr_idx   = r_hit_idx;
        wr_retr  = r_retr[r_hit_idx];
        set_shut = 1'b0;
        case (r_item.op)
            cpts_pkg::OP_SUBMIT: begin
                if (r_shut) begin
                    n_res.status = cpts_pkg::ST_CLOSED;
                    n_res.out_id = r_item.task_id;
                end else if (r_hit) begin
                    n_res = {cpts_pkg::ST_JOINED, r_id[r_hit_idx], r_prio[r_hit_idx],
                             r_retr[r_hit_idx], cpts_pkg::NF_NONE};
                end else if (!r_free_ok) begin
                    n_res.status = cpts_pkg::ST_FULL;
                    n_res.out_id = r_item.task_id;
                end else begin
                    n_res = {cpts_pkg::ST_OK, r_item.task_id, r_item.priority_req,
                             2'd0, cpts_pkg::NF_NONE};
                    wr_en = 1'b1; wr_new = 1'b1; wr_valid = 1'b1;
                    wr_idx = r_free_idx; wr_retr = 2'd0;
                end
            end
            cpts_pkg::OP_TAKE: begin
                if (!r_best_ok) begin
                    n_res.status = cpts_pkg::ST_EMPTY;
                end else begin
                    n_res = {cpts_pkg::ST_OK, r_id[r_best_idx], r_prio[r_best_idx],
                             r_retr[r_best_idx], cpts_pkg::NF_NONE};
                    wr_en = 1'b1; wr_valid = 1'b1; wr_run = 1'b1;
                    wr_idx = r_best_idx; wr_retr = r_retr[r_best_idx];
                end
            end
            cpts_pkg::OP_COMPLETE, cpts_pkg::OP_FAIL, cpts_pkg::OP_CANCEL: begin
                n_res = {cpts_pkg::ST_OK, r_id[r_hit_idx], r_prio[r_hit_idx],
                         r_retr[r_hit_idx], cpts_pkg::NF_NONE};
                if (!r_hit) begin
                    n_res = '0;
                    n_res.status = cpts_pkg::ST_NOTFOUND;
                    n_res.out_id = r_item.task_id;
                end else if ((r_item.op == cpts_pkg::OP_CANCEL) == r_run[r_hit_idx]) begin
                    n_res.status = cpts_pkg::ST_WRONG;
                end else if (r_item.op == cpts_pkg::OP_CANCEL) begin
                    wr_en = 1'b1;
                end else if (r_item.op == cpts_pkg::OP_COMPLETE) begin
                    n_res.notify = cpts_pkg::NF_COMPLETED;
                    wr_en = 1'b1;
                end else if (r_item.retryable && r_retr[r_hit_idx] < i_retry_limit) begin
                    n_res.status      = cpts_pkg::ST_REQUEUED;
                    n_res.out_retries = r_retr[r_hit_idx] + 2'd1;
                    wr_en = 1'b1; wr_valid = 1'b1; wr_retr = r_retr[r_hit_idx] + 2'd1;
                end else begin
                    n_res.notify = cpts_pkg::NF_FAILED;
                    wr_en = 1'b1;
                end
            end
            cpts_pkg::OP_CLOSE: begin
                set_shut = 1'b1;
            end
            default: n_res.status = cpts_pkg::ST_WRONG;
        endcase
    end

    // Slot table with cleared valid bits and global state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_valid[k] <= 1'b0;
            end
            r_next_order <= '0;
            r_shut       <= 1'b0;
            r_done       <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
            if (i_cmd.commit) begin
                if (set_shut) begin
                    r_shut <= 1'b1;
                end
                if (wr_en) begin
                    r_valid[wr_idx] <= wr_valid;
                    if (wr_new) begin
                        r_next_order <= r_next_order + 1'b1;
                    end
                end
            end
        end
    end

    // Slot payload, written only at commit.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_res <= n_res;
            if (wr_en) begin
                r_run[wr_idx]  <= wr_run;
                r_retr[wr_idx] <= wr_retr;
                if (wr_new) begin
                    r_id[wr_idx]    <= r_item.task_id;
                    r_prio[wr_idx]  <= r_item.priority_req;
                    r_order[wr_idx] <= r_next_order;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ----- rtl/cpts_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpts_checker: port-level assertions
// Checks strobe timing and result codes seen on the top level's ports.
// ----------------------------------------------------------------------------
module cpts_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                start,
    input logic                busy,
    input logic                o_done,
    input cpts_pkg::t_out_item o_res
);

    // An accepted transaction makes the block busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("not busy after accept");

    // No result strobe while idle before it.
    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy)) else $error("strobe without transaction");

    // Results are single-cycle strobes.
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("strobe longer than one cycle");

    // Notify only accompanies status ok.
    a_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.notify != cpts_pkg::NF_NONE) |-> o_res.status == cpts_pkg::ST_OK)
        else $error("notify with non-ok status");

endmodule

bind coalescing_priority_transfer_scheduler cpts_checker u_cpts_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done),
    .o_res   (o_res)
);
